// ===== design/mtbr_pkg.sv =====
// Shared types, register codes and the sample scaling function of the
// motion-triggered burst reporter. No dependencies.
`timescale 1ns / 1ps

package mtbr_pkg;

	localparam int unsigned THR_W    = 9;
	localparam int unsigned BLEN_W   = 8;
	localparam int unsigned ACC_W    = 9;
	localparam int unsigned RAW_W    = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [THR_W-1:0]  THR_RESET  = 9'd100;
	localparam logic [BLEN_W-1:0] BLEN_RESET = 8'd10;

	// Register index, taken from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_BURST_LEN = 1'b1;

	typedef logic signed [ACC_W-1:0] accel_t;

	typedef struct packed {
		logic [THR_W-1:0]  change_threshold;
		logic [BLEN_W-1:0] burst_length;
	} cfg_t;

	typedef struct packed {
		logic              data_ready;
		logic              x_ready;
		logic              y_ready;
		logic              z_ready;
		logic [RAW_W-1:0]  raw_x;
		logic [RAW_W-1:0]  raw_y;
		logic [RAW_W-1:0]  raw_z;
		logic [TIME_W-1:0] event_time;
	} event_t;

	// floor(raw / 4) * 100 / 4096, the division truncated toward zero
	function automatic accel_t scale_raw(input logic [RAW_W-1:0] raw);
		logic signed [13:0] q;
		logic signed [20:0] p;
		logic signed [20:0] b;
		q = 14'($signed(raw) >>> 2);
		p = 21'(q) * 21'sd100;
		b = p[20] ? p + 21'sd4095 : p;
		b = b >>> 12;
		return b[ACC_W-1:0];
	endfunction

endpackage

// ===== design/mtbr_event_if.sv =====
// Input channel of the burst reporter: valid/ready handshake with one
// accelerometer event. Depends on nothing.
`timescale 1ns / 1ps

interface mtbr_event_if;
	logic        valid;
	logic        ready;
	logic        data_ready;
	logic        x_ready;
	logic        y_ready;
	logic        z_ready;
	logic [15:0] raw_x;
	logic [15:0] raw_y;
	logic [15:0] raw_z;
	logic [31:0] event_time;

	modport source (
		output valid, data_ready, x_ready, y_ready, z_ready, raw_x, raw_y, raw_z,
		       event_time,
		input  ready
	);
	modport sink (
		input  valid, data_ready, x_ready, y_ready, z_ready, raw_x, raw_y, raw_z,
		       event_time,
		output ready
	);
endinterface

// ===== design/mtbr_report_if.sv =====
// Output channel of the burst reporter: valid/ready handshake with one
// report. Depends on nothing.
`timescale 1ns / 1ps

interface mtbr_report_if;
	logic              valid;
	logic              ready;
	logic [31:0]       report_time;
	logic signed [8:0] accel_x;
	logic signed [8:0] accel_y;
	logic signed [8:0] accel_z;

	modport source (
		output valid, report_time, accel_x, accel_y, accel_z,
		input  ready
	);
	modport sink (
		input  valid, report_time, accel_x, accel_y, accel_z,
		output ready
	);
endinterface

// ===== design/mtbr_cfg_regs.sv =====
// APB-style configuration registers: change threshold and burst length.
// Depends on mtbr_pkg.
`timescale 1ns / 1ps

module mtbr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mtbr_pkg::PADDR_W-1:0]  paddr,
	input  logic [mtbr_pkg::PDATA_W-1:0]  pwdata,
	output logic [mtbr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output mtbr_pkg::cfg_t                cfg
);

	logic [mtbr_pkg::THR_W-1:0]  threshold_q;
	logic [mtbr_pkg::BLEN_W-1:0] burst_len_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mtbr_pkg::THR_RESET;
			burst_len_q <= mtbr_pkg::BLEN_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				mtbr_pkg::REG_THRESHOLD: threshold_q <= pwdata[mtbr_pkg::THR_W-1:0];
				mtbr_pkg::REG_BURST_LEN: burst_len_q <= pwdata[mtbr_pkg::BLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			mtbr_pkg::REG_THRESHOLD: prdata = 32'(threshold_q);
			mtbr_pkg::REG_BURST_LEN: prdata = 32'(burst_len_q);
			default:                 prdata = '0;
		endcase
	end

	assign cfg.change_threshold = threshold_q;
	assign cfg.burst_length     = burst_len_q;

endmodule

// ===== design/mtbr_in_stage.sv =====
// Input register stage: captures one event transaction and holds it until
// the evaluation stage takes it. Depends on mtbr_pkg and mtbr_event_if.
`timescale 1ns / 1ps

module mtbr_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	mtbr_event_if.sink      evt,
	input  logic            take,
	output logic            valid_s1,
	output mtbr_pkg::event_t event_s1
);

	logic            valid_q;
	mtbr_pkg::event_t event_q;

	assign evt.ready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			event_q.data_ready <= evt.data_ready;
			event_q.x_ready    <= evt.x_ready;
			event_q.y_ready    <= evt.y_ready;
			event_q.z_ready    <= evt.z_ready;
			event_q.raw_x      <= evt.raw_x;
			event_q.raw_y      <= evt.raw_y;
			event_q.raw_z      <= evt.raw_z;
			event_q.event_time <= evt.event_time;
		end
	end

	assign valid_s1 = valid_q;
	assign event_s1 = event_q;

	// a held event must not vanish while the next stage is blocked
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !take |=> valid_q)
		else $error("input stage dropped a stalled event");

endmodule

// ===== design/mtbr_core.sv =====
// Evaluation stage: scales new samples, updates axis state, runs the
// idle/burst control and loads the report register. Depends on mtbr_pkg
// and mtbr_report_if.
`timescale 1ns / 1ps

module mtbr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  mtbr_pkg::cfg_t   cfg,
	input  logic             valid_s1,
	input  mtbr_pkg::event_t event_s1,
	output logic             take,
	mtbr_report_if.source    rpt
);

	mtbr_pkg::accel_t cur_x_q, cur_y_q, cur_z_q;
	mtbr_pkg::accel_t prev_x_q, prev_y_q, prev_z_q;
	mtbr_pkg::accel_t cur_x_d, cur_y_d, cur_z_d;
	mtbr_pkg::accel_t prev_x_d, prev_y_d, prev_z_d;
	logic             bursting_q;
	logic [7:0]       sent_q;
	logic [7:0]       sent_inc;
	logic             burst_done;
	logic             moved_any;
	logic             emit;
	logic             out_valid_q;
	logic [31:0]      time_q;
	mtbr_pkg::accel_t out_x_q, out_y_q, out_z_q;
	logic             upd_x, upd_y, upd_z;

	function automatic logic moved(input mtbr_pkg::accel_t now,
		input mtbr_pkg::accel_t was, input logic [8:0] thr);
		logic signed [9:0] d;
		logic [9:0]        mag;
		d   = 10'(now) - 10'(was);
		mag = d[9] ? 10'(-d) : 10'(d);
		return mag > {1'b0, thr};
	endfunction

	assign take = valid_s1 && (!out_valid_q || rpt.ready);

	assign upd_x = event_s1.data_ready & event_s1.x_ready;
	assign upd_y = event_s1.data_ready & event_s1.y_ready;
	assign upd_z = event_s1.data_ready & event_s1.z_ready;

	always_comb begin
		cur_x_d  = upd_x ? mtbr_pkg::scale_raw(event_s1.raw_x) : cur_x_q;
		cur_y_d  = upd_y ? mtbr_pkg::scale_raw(event_s1.raw_y) : cur_y_q;
		cur_z_d  = upd_z ? mtbr_pkg::scale_raw(event_s1.raw_z) : cur_z_q;
		prev_x_d = upd_x ? cur_x_q : prev_x_q;
		prev_y_d = upd_y ? cur_y_q : prev_y_q;
		prev_z_d = upd_z ? cur_z_q : prev_z_q;
	end

	assign moved_any = moved(cur_x_d, prev_x_d, cfg.change_threshold)
	                 | moved(cur_y_d, prev_y_d, cfg.change_threshold)
	                 | moved(cur_z_d, prev_z_d, cfg.change_threshold);

	assign emit     = bursting_q || moved_any;
	assign sent_inc = sent_q + 8'd1;
	// sent >= length - 2, with a length of zero ending at once
	assign burst_done = ({1'b0, sent_inc} + 9'd1) >= {1'b0, cfg.burst_length};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			cur_z_q    <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_z_q   <= '0;
			bursting_q <= 1'b0;
			sent_q     <= '0;
		end else if (take) begin
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			cur_z_q  <= cur_z_d;
			prev_x_q <= prev_x_d;
			prev_y_q <= prev_y_d;
			prev_z_q <= prev_z_d;
			if (!bursting_q) begin
				if (moved_any) begin
					bursting_q <= 1'b1;
					sent_q     <= '0;
				end
			end else begin
				sent_q <= sent_inc;
				if (burst_done) begin
					bursting_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			time_q  <= event_s1.event_time;
			out_x_q <= cur_x_d;
			out_y_q <= cur_y_d;
			out_z_q <= cur_z_d;
		end
	end

	assign rpt.valid       = out_valid_q;
	assign rpt.report_time = time_q;
	assign rpt.accel_x     = out_x_q;
	assign rpt.accel_y     = out_y_q;
	assign rpt.accel_z     = out_z_q;

	a_start_burst: assert property (@(posedge clk) disable iff (!arst_n)
		take && !bursting_q && moved_any |=> bursting_q)
		else $error("motion seen in idle did not start a burst");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |=> out_valid_q)
		else $error("report lost on its way to the output register");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bursting_q) |-> $past(take))
		else $error("burst ended without an event");

endmodule

// ===== design/motion_triggered_burst_reporter_top.sv =====
// Flow: an accepted event is registered in the input stage; the evaluation stage
// takes it when the report register is free or read, and loads any report there.
// Throughput: one event per cycle; the single evaluation stage closes the axis and
// burst state loop every cycle, so the rate is bounded only by report back-pressure.
// Reset (arst_n low, asynchronous): axis values, burst state and both stages clear;
// threshold returns to 100 and burst length to 10.
`timescale 1ns / 1ps

module motion_triggered_burst_reporter_top (
	input  logic        clk,
	input  logic        arst_n,
	mtbr_event_if.sink  evt,
	mtbr_report_if.source rpt,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mtbr_pkg::cfg_t   cfg;
	logic             take;
	logic             valid_s1;
	mtbr_pkg::event_t event_s1;

	mtbr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtbr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.take     (take),
		.valid_s1 (valid_s1),
		.event_s1 (event_s1)
	);

	mtbr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.event_s1 (event_s1),
		.take     (take),
		.rpt      (rpt)
	);

endmodule
